// ===== hw/rtl/mla_pkg.sv =====
package mla_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned LimbBits = 32;

  typedef enum logic [3:0] {
    ModeInc    = 4'd0,
    ModeAdd    = 4'd1,
    ModeAddInc = 4'd2,
    ModeDec    = 4'd3,
    ModeSub    = 4'd4,
    ModeSubDec = 4'd5,
    ModeMul    = 4'd6,
    ModeMac    = 4'd7,
    ModeMac2   = 4'd8,
    ModeDiv    = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusDivZero = 2'd1,
    StatusQOvf    = 2'd2
  } status_e;

  // Result fields riding along the divider stages.
  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic [WordBits-1:0] word0;
    logic [WordBits-1:0] word1;
    logic                flag;
    status_e             status;
  } res_t;

endpackage

// ===== hw/rtl/mla_div_step.sv =====
module mla_div_step #(
  parameter int unsigned LIMB_BITS = mla_pkg::LimbBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mla_pkg::res_t            res_i,
  input  logic [LIMB_BITS-1:0]     rem_i,
  input  logic [2*LIMB_BITS-1:0]   quo_i,
  input  logic [LIMB_BITS-1:0]     dvs_i,
  output mla_pkg::res_t            res_o,
  output logic [LIMB_BITS-1:0]     rem_o,
  output logic [2*LIMB_BITS-1:0]   quo_o,
  output logic [LIMB_BITS-1:0]     dvs_o
);

  logic [LIMB_BITS-1:0]   rem_d, rem_q;
  logic [2*LIMB_BITS-1:0] quo_d, quo_q;
  logic [LIMB_BITS-1:0]   dvs_q;
  logic                   valid_q;
  mla_pkg::res_t          res_q;

  // two restoring-division steps per stage
  always_comb begin
    logic [LIMB_BITS:0] t;
    logic               qb;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int k = 0; k < 2; k++) begin
      t  = {rem_d, quo_d[2*LIMB_BITS-1]};
      qb = (t >= {1'b0, dvs_i});
      if (qb) begin
        t = t - {1'b0, dvs_i};
      end
      rem_d = t[LIMB_BITS-1:0];
      quo_d = {quo_d[2*LIMB_BITS-2:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_i;
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;

endmodule

// ===== hw/rtl/multiprecision_limb_alu.sv =====
// Multi-precision limb ALU: one limb operation per transaction.
//
// Command channel: a transaction is taken at a rising edge with start_i high
// and busy_o low. busy_o is always low: the unit is fully pipelined and takes
// a new transaction every cycle.
// Result channel: done_o is high for exactly one cycle with primary_word_o,
// second_word_o, carry_flag_o and status_o. The receiver cannot stall, and
// none is needed since nothing ever backs up inside.
// Every mode takes the same path through the pipeline. The divider is
// a chain of LIMB_BITS stages that each retire two quotient bits of the
// double-limb dividend. Add/sub and multiply results finish early and ride
// the same chain so results leave in order.
// Stage 1 registers the add/sub result and the limb product; stage 2 adds
// the multiply-add addends and loads the divider; the divider stages follow,
// then an output register.
// Throughput: one transaction per cycle.
// Reset: async active-low; clears all valid bits, so no spurious done_o.
module multiprecision_limb_alu #(
  parameter int unsigned LIMB_BITS = mla_pkg::LimbBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [31:0] operand_c_i,
  input  logic [31:0] operand_d_i,
  output logic        done_o,
  output logic [31:0] primary_word_o,
  output logic [31:0] second_word_o,
  output logic        carry_flag_o,
  output logic [1:0]  status_o
);

  localparam int unsigned L = LIMB_BITS;
  localparam int unsigned W = mla_pkg::WordBits;

  assign busy_o = 1'b0;

  // ---------------- stage 1: add/sub and product ----------------
  logic                v1_q;
  mla_pkg::mode_e      mode1_q;
  logic [L-1:0]        a1_q, b1_q, c1_q, d1_q, w1_q;
  logic                f1_q;
  logic [2*L-1:0]      p1_q;

  logic [L-1:0] a_l, b_l, addend;
  logic         cin;
  logic [L:0]   sum_w, dif_w;
  logic [L-1:0] w1_d;
  logic         f1_d;

  assign a_l = operand_a_i[L-1:0];
  assign b_l = operand_b_i[L-1:0];

  always_comb begin
    addend = b_l;
    cin    = 1'b0;
    case (mla_pkg::mode_e'(mode_i))
      mla_pkg::ModeInc, mla_pkg::ModeDec: addend = L'(1);
      mla_pkg::ModeAddInc, mla_pkg::ModeSubDec: cin = 1'b1;
      default: ;
    endcase
    sum_w = {1'b0, a_l} + {1'b0, addend} + (L+1)'(cin);
    dif_w = {1'b0, a_l} - {1'b0, addend} - (L+1)'(cin);
    case (mla_pkg::mode_e'(mode_i))
      mla_pkg::ModeInc, mla_pkg::ModeAdd, mla_pkg::ModeAddInc: begin
        w1_d = sum_w[L-1:0];
        f1_d = sum_w[L];
      end
      mla_pkg::ModeDec, mla_pkg::ModeSub, mla_pkg::ModeSubDec: begin
        w1_d = dif_w[L-1:0];
        f1_d = dif_w[L];  // borrow out
      end
      default: begin
        w1_d = '0;
        f1_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mla_pkg::mode_e'(mode_i);
    a1_q    <= a_l;
    b1_q    <= b_l;
    c1_q    <= operand_c_i[L-1:0];
    d1_q    <= operand_d_i[L-1:0];
    w1_q    <= w1_d;
    f1_q    <= f1_d;
    p1_q    <= (2*L)'(a_l) * (2*L)'(b_l);
  end

  // ---------------- stage 2: multiply-add, divider load ----------------
  mla_pkg::res_t  res2_d;
  logic [2*L-1:0] mac_w;
  logic [L-1:0]   rem2_d, dvs2_d;
  logic [2*L-1:0] quo2_d;
  logic [L-1:0]   all_ones;

  assign all_ones = '1;

  always_comb begin
    mac_w = p1_q;
    if (mode1_q == mla_pkg::ModeMac || mode1_q == mla_pkg::ModeMac2) begin
      mac_w = mac_w + (2*L)'(c1_q);
    end
    if (mode1_q == mla_pkg::ModeMac2) begin
      mac_w = mac_w + (2*L)'(d1_q);
    end

    res2_d        = '0;
    res2_d.valid  = v1_q;
    res2_d.status = mla_pkg::StatusOk;
    rem2_d        = '0;
    quo2_d        = {a1_q, b1_q};
    dvs2_d        = d1_q;
    case (mode1_q)
      mla_pkg::ModeInc, mla_pkg::ModeAdd, mla_pkg::ModeAddInc,
      mla_pkg::ModeDec, mla_pkg::ModeSub, mla_pkg::ModeSubDec: begin
        res2_d.word0 = W'(w1_q);
        res2_d.flag  = f1_q;
      end
      mla_pkg::ModeMul, mla_pkg::ModeMac, mla_pkg::ModeMac2: begin
        res2_d.word0 = W'(mac_w[L-1:0]);
        res2_d.word1 = W'(mac_w[2*L-1:L]);
      end
      mla_pkg::ModeDiv: begin
        if (d1_q == '0) begin
          res2_d.word0  = W'(b1_q);
          res2_d.word1  = W'(all_ones);
          res2_d.status = mla_pkg::StatusDivZero;
        end else begin
          res2_d.is_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- divider chain ----------------
  mla_pkg::res_t  res_s [0:L];
  logic [L-1:0]   rem_s [0:L];
  logic [2*L-1:0] quo_s [0:L];
  logic [L-1:0]   dvs_s [0:L];

  mla_pkg::res_t  res2_q;
  mla_pkg::res_t  res2_v;
  logic [L-1:0]   rem2_q, dvs2_q;
  logic [2*L-1:0] quo2_q;
  logic           v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res2_q <= res2_d;
    rem2_q <= rem2_d;
    quo2_q <= quo2_d;
    dvs2_q <= dvs2_d;
  end

  always_comb begin
    res2_v       = res2_q;
    res2_v.valid = v2_q;
  end
  assign res_s[0] = res2_v;
  assign rem_s[0] = rem2_q;
  assign quo_s[0] = quo2_q;
  assign dvs_s[0] = dvs2_q;

  for (genvar g = 0; g < L; g++) begin : g_div
    mla_div_step #(
      .LIMB_BITS(L)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .res_i (res_s[g]),
      .rem_i (rem_s[g]),
      .quo_i (quo_s[g]),
      .dvs_i (dvs_s[g]),
      .res_o (res_s[g+1]),
      .rem_o (rem_s[g+1]),
      .quo_o (quo_s[g+1]),
      .dvs_o (dvs_s[g+1])
    );
  end

  // ---------------- output register ----------------
  logic        done_q;
  logic [W-1:0] pw_q, sw_q;
  logic        cf_q;
  mla_pkg::status_e st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_s[L].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_s[L].is_div) begin
      pw_q <= W'(rem_s[L]);
      sw_q <= W'(quo_s[L][L-1:0]);
      cf_q <= 1'b0;
      st_q <= (quo_s[L][2*L-1:L] != '0) ? mla_pkg::StatusQOvf : mla_pkg::StatusOk;
    end else begin
      pw_q <= res_s[L].word0;
      sw_q <= res_s[L].word1;
      cf_q <= res_s[L].flag;
      st_q <= res_s[L].status;
    end
  end

  assign done_o         = done_q;
  assign primary_word_o = pw_q;
  assign second_word_o  = sw_q;
  assign carry_flag_o   = cf_q;
  assign status_o       = st_q;

endmodule

// ===== bench/tb_multiprecision_limb_alu.sv =====
module tb_multiprecision_limb_alu;

  // Result record for one limb operation.
  typedef struct {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        flag;
    logic [1:0]  status;
  } limb_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [3:0]  mode_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic [31:0] operand_c_i = '0;
  logic [31:0] operand_d_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] primary_word_o;
  logic [31:0] second_word_o;
  logic        carry_flag_o;
  logic [1:0]  status_o;

  limb_res_t pending_results[$];
  int        fail_count = 0;
  bit        idle_enable = 1'b1;

  multiprecision_limb_alu DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i,
    .operand_a_i, .operand_b_i, .operand_c_i, .operand_d_i,
    .done_o, .primary_word_o, .second_word_o, .carry_flag_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  // Compute the expected limb result of one transaction.
  function automatic limb_res_t limb_compute(logic [3:0] mode, logic [31:0] a,
                                             logic [31:0] b, logic [31:0] c,
                                             logic [31:0] d);
    limb_res_t   r;
    logic [32:0] s;
    logic [63:0] x;
    logic [63:0] q;
    r = '{32'd0, 32'd0, 1'b0, mla_pkg::StatusOk};
    case (mode)
      mla_pkg::ModeInc: begin
        s = {1'b0, a} + 33'd1;
        r.word0 = s[31:0]; r.flag = s[32];
      end
      mla_pkg::ModeAdd: begin
        s = {1'b0, a} + {1'b0, b};
        r.word0 = s[31:0]; r.flag = s[32];
      end
      mla_pkg::ModeAddInc: begin
        s = {1'b0, a} + {1'b0, b} + 33'd1;
        r.word0 = s[31:0]; r.flag = s[32];
      end
      mla_pkg::ModeDec: begin
        r.word0 = a - 32'd1; r.flag = (a == 32'd0);
      end
      mla_pkg::ModeSub: begin
        r.word0 = a - b; r.flag = (b > a);
      end
      mla_pkg::ModeSubDec: begin
        r.word0 = a - b - 32'd1; r.flag = (b >= a);
      end
      mla_pkg::ModeMul, mla_pkg::ModeMac, mla_pkg::ModeMac2: begin
        x = {32'd0, a} * {32'd0, b};
        if (mode != mla_pkg::ModeMul) x = x + {32'd0, c};
        if (mode == mla_pkg::ModeMac2) x = x + {32'd0, d};
        r.word0 = x[31:0]; r.word1 = x[63:32];
      end
      mla_pkg::ModeDiv: begin
        if (d == 32'd0) begin
          r.status = mla_pkg::StatusDivZero; r.word1 = '1; r.word0 = b;
        end else begin
          x = {a, b};
          q = x / {32'd0, d};
          r.word0 = 32'(x % {32'd0, d});
          r.word1 = q[31:0];
          if (q[63:32] != 32'd0) r.status = mla_pkg::StatusQOvf;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one transaction; optional idle burst first.
  task automatic send_op(logic [3:0] mode, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [31:0] d);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= mode;
    operand_a_i <= a;
    operand_b_i <= b;
    operand_c_i <= c;
    operand_d_i <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(limb_compute(mode, a, b, c, d));
  endtask

  task automatic end_sends();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    limb_res_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word0=%h", primary_word_o);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (primary_word_o !== e.word0) begin
          $error("primary_word exp %h got %h", e.word0, primary_word_o); fail_count++;
        end
        if (second_word_o !== e.word1) begin
          $error("second_word exp %h got %h", e.word1, second_word_o); fail_count++;
        end
        if (carry_flag_o !== e.flag) begin
          $error("carry_flag exp %b got %b", e.flag, carry_flag_o); fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return '1;
      2: return 32'(1) << $urandom_range(0, 31);
      3: return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_op(mla_pkg::ModeInc, '1, 0, 0, 0);
    send_op(mla_pkg::ModeInc, 32'd5, 0, 0, 0);
    send_op(mla_pkg::ModeAdd, '1, 32'd1, 0, 0);
    send_op(mla_pkg::ModeAdd, 32'h1234, 32'h4321, 0, 0);
    send_op(mla_pkg::ModeAddInc, '1, '1, 0, 0);
    send_op(mla_pkg::ModeAddInc, 0, 0, 0, 0);
    send_op(mla_pkg::ModeDec, 0, 0, 0, 0);
    send_op(mla_pkg::ModeDec, 32'd1, 0, 0, 0);
    send_op(mla_pkg::ModeSub, 0, '1, 0, 0);
    send_op(mla_pkg::ModeSub, 32'd7, 32'd7, 0, 0);
    send_op(mla_pkg::ModeSubDec, 32'd7, 32'd7, 0, 0);
    send_op(mla_pkg::ModeSubDec, 32'd8, 32'd7, 0, 0);
    send_op(mla_pkg::ModeMul, '1, '1, 0, 0);
    send_op(mla_pkg::ModeMac, '1, '1, '1, 0);
    send_op(mla_pkg::ModeMac2, '1, '1, '1, '1);
    send_op(mla_pkg::ModeDiv, 32'd3, 32'd9, 0, 0);   // zero divisor
    send_op(mla_pkg::ModeDiv, '1, '1, 0, 32'd1);     // quotient overflow
    send_op(mla_pkg::ModeDiv, 32'd4, '1, 0, 32'd5);
    send_op(mla_pkg::ModeDiv, 0, '1, 0, '1);
    send_op(4'd10, '1, '1, '1, '1);                  // unused modes
    send_op(4'd15, '1, '1, '1, '1);
    end_sends();
  endtask

  task automatic test_random(int count);
    logic [3:0] m;
    for (int i = 0; i < count; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_op(m, rand_word(), rand_word(), rand_word(), rand_word());
    end
    end_sends();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();          // sender holds off until all results are back
    test_random(900);
    idle_enable = 1'b0;      // back-to-back tail
    test_random(230);
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("multiprecision_limb_alu test passed");
    end else begin
      $display("multiprecision_limb_alu test failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("multiprecision_limb_alu test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mla_pkg.sv
hw/rtl/mla_div_step.sv
hw/rtl/multiprecision_limb_alu.sv
bench/tb_multiprecision_limb_alu.sv
